// ===== src/prpb_pkg.sv =====
// Package for the page-pointer entry builder: widths, codes, result type and helpers.
`timescale 1ns / 1ps
`default_nettype none

package prpb_pkg;

  // Defaults for the top-level parameters. The page size must be a power of two.
  localparam int PRPB_PAGE_BYTES  = 4096;
  localparam int PRPB_MAX_ENTRIES = 513;

  // Fixed field widths.
  localparam int ADDR_W = 64;
  localparam int LEN_W  = 18;
  localparam int IDX_W  = 10;
  localparam int STAT_W = 3;

  // At most this many results come out of one segment.
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Completion codes carried on the status field.
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_RETRY      = 3'd1,
    ST_FAULT      = 3'd2,
    ST_TOO_MANY   = 3'd3,
    ST_NO_ENTRIES = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  // One result item.
  typedef struct packed {
    logic              entry_valid;
    logic [ADDR_W-1:0] entry_addr;
    logic [IDX_W-1:0]  entry_index;
    logic              done_res;
    status_t           status;
    logic [IDX_W-1:0]  entry_count;
    logic              last;
  } res_t;

  // A failure or done result that carries no entry.
  function automatic res_t end_res(status_t st, logic [IDX_W-1:0] cnt);
    res_t r;
    r.entry_valid = 1'b0;
    r.entry_addr  = '0;
    r.entry_index = '0;
    r.done_res    = 1'b1;
    r.status      = st;
    r.entry_count = cnt;
    r.last        = 1'b1;
    return r;
  endfunction

  // A result carrying a new page entry; done and last are settled later.
  function automatic res_t entry_res(logic [ADDR_W-1:0] addr, logic [IDX_W-1:0] idx,
                                     logic [IDX_W-1:0] cnt);
    res_t r;
    r.entry_valid = 1'b1;
    r.entry_addr  = addr;
    r.entry_index = idx;
    r.done_res    = 1'b0;
    r.status      = ST_OK;
    r.entry_count = cnt;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/prpb_page_unit.sv =====
// Shared page arithmetic: page offset, bytes taken from the current page and advanced pointers.
`timescale 1ns / 1ps
`default_nettype none

module prpb_page_unit #(
  parameter int PAGE_BYTES = prpb_pkg::PRPB_PAGE_BYTES
) (
  input  wire logic                                  new_page,
  input  wire logic [prpb_pkg::ADDR_W-1:0]           addr,
  input  wire logic [prpb_pkg::LEN_W-1:0]            len,
  input  wire logic [$clog2(PAGE_BYTES + 1)-1:0]     page_left,
  output logic                                       off_nz,
  output logic [prpb_pkg::ADDR_W-1:0]                addr_next,
  output logic [prpb_pkg::LEN_W-1:0]                 len_next,
  output logic [$clog2(PAGE_BYTES + 1)-1:0]          page_left_next
);
  import prpb_pkg::*;

  localparam int PG_W = $clog2(PAGE_BYTES);
  localparam int PL_W = $clog2(PAGE_BYTES + 1);
  localparam int XW   = (PL_W > LEN_W) ? PL_W : LEN_W;

  logic [PG_W-1:0] off;
  logic [PL_W-1:0] avail;
  logic [XW-1:0]   avail_x;
  logic [XW-1:0]   len_x;
  logic [XW-1:0]   take;

  // Offset within the page; a fresh page offers what is left after the offset.
  assign off    = addr[PG_W-1:0];
  assign off_nz = (off != '0);
  assign avail  = new_page ? (PL_W'(PAGE_BYTES) - PL_W'(off)) : page_left;

  // Take the smaller of the page room and the bytes left in the segment.
  assign avail_x = XW'(avail);
  assign len_x   = XW'(len);
  assign take    = (avail_x < len_x) ? avail_x : len_x;

  assign addr_next      = addr + ADDR_W'(take);
  assign len_next       = LEN_W'(len_x - take);
  assign page_left_next = PL_W'(avail_x - take);

endmodule

`default_nettype wire

// ===== src/prpb_out_reg.sv =====
// Output register that holds one result until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module prpb_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire prpb_pkg::res_t  push_res,
  output logic                 free,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output prpb_pkg::res_t       out_res
);
  import prpb_pkg::*;

  // The slot can take a new result when it is empty or being drained now.
  assign free = !out_valid || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, loaded only on a push so a stalled result holds.
  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= push_res;
    end
  end

endmodule

`default_nettype wire

// ===== src/nvme_prp_entry_builder_unit.sv =====
// Top level of the page-pointer entry builder: sequencer, running state and result staging.
//
// Segments of one transfer arrive on the input channel (in_valid / in_stall) in order;
// page entries and completion results leave on the output channel (out_valid /
// out_stall). A transfer is accepted when valid is high and stall is low.
// A segment is taken only while the sequencer is idle. It then walks the segment one
// page a cycle through the shared page unit while the output slot is free; the next
// segment is taken only once the loop has ended and the one-result staging register
// in front of the output register has passed on any result it holds.
// The newest entry is held back in that staging register so that its done and last flags can be set
// once the sequencer knows whether more results follow.
// When the receiver stalls, the output register holds its result and the sequencer
// waits on every step of the page walk and of the finish; a new segment is still
// accepted while a finished result waits in the output register.
// Reset (synchronous, active high) clears the running transfer state and empties the
// output register. PAGE_BYTES must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module nvme_prp_entry_builder_unit #(
  parameter int PAGE_BYTES  = prpb_pkg::PRPB_PAGE_BYTES,
  parameter int MAX_ENTRIES = prpb_pkg::PRPB_MAX_ENTRIES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          first_segment,
  input  wire logic                          last_segment,
  input  wire logic                          zero_copy_path,
  input  wire logic                          translate_failed,
  input  wire logic [prpb_pkg::ADDR_W-1:0]   seg_addr,
  input  wire logic [prpb_pkg::LEN_W-1:0]    seg_len,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               entry_valid,
  output logic [prpb_pkg::ADDR_W-1:0]        entry_addr,
  output logic [prpb_pkg::IDX_W-1:0]         entry_index,
  output logic                               done_res,
  output logic [prpb_pkg::STAT_W-1:0]        status,
  output logic [prpb_pkg::IDX_W-1:0]         entry_count,
  output logic                               last
);
  import prpb_pkg::*;

  localparam int PL_W = $clog2(PAGE_BYTES + 1);
  localparam int EM_W = $clog2(MAX_ENTRIES + 1);

  state_t            state, state_next;
  logic [ADDR_W-1:0] addr, addr_nx;
  logic [LEN_W-1:0]  len, len_nx;
  logic [PL_W-1:0]   page_left, page_left_nx;
  logic [ADDR_W-1:0] expected_addr, expected_addr_nx;
  logic [EM_W-1:0]   entries_made, entries_made_nx;
  status_t           failed_code, failed_code_nx;
  logic              zero_copy_mode, zero_copy_mode_nx;
  logic [RES_W-1:0]  nres, nres_nx;
  logic              last_seg, last_seg_nx;
  res_t              pend, pend_nx;

  logic              in_accept;
  logic              push;
  res_t              push_res;
  logic              free;
  res_t              out_res;
  logic              new_page;
  logic              off_nz;
  logic [ADDR_W-1:0] pu_addr_next;
  logic [LEN_W-1:0]  pu_len_next;
  logic [PL_W-1:0]   pu_page_left_next;
  status_t           fb_code;
  status_t           acc_fb;
  logic [EM_W-1:0]   acc_em;
  logic              acc_zc;
  status_t           acc_fc;
  logic              held_fits;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign new_page  = (page_left == '0);
  assign fb_code   = zero_copy_mode ? ST_RETRY : ST_FAULT;

  // A held result goes out ahead of a failure unless all result slots are used.
  assign held_fits = (nres != '0) && (nres < RES_W'(MAX_RESULTS));

  // State of the transfer as seen by an arriving segment.
  assign acc_em = first_segment ? '0 : entries_made;
  assign acc_fc = first_segment ? ST_OK : failed_code;
  assign acc_zc = first_segment ? zero_copy_path : zero_copy_mode;
  assign acc_fb = acc_zc ? ST_RETRY : ST_FAULT;

  // Shared page arithmetic.
  prpb_page_unit #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_page (
    .new_page      (new_page),
    .addr          (addr),
    .len           (len),
    .page_left     (page_left),
    .off_nz        (off_nz),
    .addr_next     (pu_addr_next),
    .len_next      (pu_len_next),
    .page_left_next(pu_page_left_next)
  );

  // Output staging register.
  prpb_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .free     (free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign entry_valid = out_res.entry_valid;
  assign entry_addr  = out_res.entry_addr;
  assign entry_index = out_res.entry_index;
  assign done_res    = out_res.done_res;
  assign status      = out_res.status;
  assign entry_count = out_res.entry_count;
  assign last        = out_res.last;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, running state and result pushes.
  always_comb begin
    state_next        = state;
    addr_nx           = addr;
    len_nx            = len;
    page_left_nx      = page_left;
    expected_addr_nx  = expected_addr;
    entries_made_nx   = entries_made;
    failed_code_nx    = failed_code;
    zero_copy_mode_nx = zero_copy_mode;
    nres_nx           = nres;
    last_seg_nx       = last_seg;
    pend_nx           = pend;
    push              = 1'b0;
    push_res          = pend;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (first_segment) begin
            page_left_nx      = '0;
            expected_addr_nx  = '0;
            entries_made_nx   = '0;
            failed_code_nx    = ST_OK;
            zero_copy_mode_nx = zero_copy_path;
          end
          if (acc_fc != ST_OK) begin
            state_next = S_IDLE;
          end else if (translate_failed) begin
            failed_code_nx = acc_fb;
            pend_nx        = end_res(acc_fb, IDX_W'(acc_em));
            state_next     = S_FINISH;
          end else begin
            addr_nx     = seg_addr;
            len_nx      = seg_len;
            last_seg_nx = last_segment;
            nres_nx     = '0;
            state_next  = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (free) begin
          if (len == '0) begin
            // Segment used up: settle the flags of the held result.
            if (last_seg && entries_made == '0) begin
              failed_code_nx = ST_NO_ENTRIES;
              pend_nx        = end_res(ST_NO_ENTRIES, IDX_W'(entries_made));
              state_next     = S_FINISH;
            end else if (last_seg) begin
              if (nres != '0) begin
                pend_nx.done_res = 1'b1;
                pend_nx.last     = 1'b1;
              end else begin
                pend_nx = end_res(ST_OK, IDX_W'(entries_made));
              end
              state_next = S_FINISH;
            end else if (nres != '0) begin
              pend_nx.last = 1'b1;
              state_next   = S_FINISH;
            end else begin
              state_next = S_IDLE;
            end
          end else if (new_page) begin
            // A new page is needed: check it, then emit and consume.
            if (off_nz && (entries_made != '0 || zero_copy_mode)) begin
              push           = held_fits;
              failed_code_nx = fb_code;
              pend_nx        = end_res(fb_code, IDX_W'(entries_made));
              state_next     = S_FINISH;
            end else if (entries_made >= EM_W'(MAX_ENTRIES)) begin
              push           = held_fits;
              failed_code_nx = ST_TOO_MANY;
              pend_nx        = end_res(ST_TOO_MANY, IDX_W'(entries_made));
              state_next     = S_FINISH;
            end else if (nres >= RES_W'(MAX_RESULTS)) begin
              // The failure takes the place of the held result.
              failed_code_nx = fb_code;
              pend_nx        = end_res(fb_code, IDX_W'(entries_made));
              state_next     = S_FINISH;
            end else begin
              push             = (nres != '0);
              pend_nx          = entry_res(addr, IDX_W'(entries_made),
                                           IDX_W'(entries_made + 1'b1));
              nres_nx          = nres + 1'b1;
              entries_made_nx  = entries_made + 1'b1;
              addr_nx          = pu_addr_next;
              len_nx           = pu_len_next;
              page_left_nx     = pu_page_left_next;
              expected_addr_nx = pu_addr_next;
            end
          end else if (addr != expected_addr) begin
            // A partly used page must be continued at the expected address.
            push           = held_fits;
            failed_code_nx = fb_code;
            pend_nx        = end_res(fb_code, IDX_W'(entries_made));
            state_next     = S_FINISH;
          end else begin
            addr_nx          = pu_addr_next;
            len_nx           = pu_len_next;
            page_left_nx     = pu_page_left_next;
            expected_addr_nx = pu_addr_next;
          end
        end
      end
      S_FINISH: begin
        if (free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Transfer state kept across segments.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_left      <= '0;
      expected_addr  <= '0;
      entries_made   <= '0;
      failed_code    <= ST_OK;
      zero_copy_mode <= 1'b0;
    end else begin
      page_left      <= page_left_nx;
      expected_addr  <= expected_addr_nx;
      entries_made   <= entries_made_nx;
      failed_code    <= failed_code_nx;
      zero_copy_mode <= zero_copy_mode_nx;
    end
  end

  // Working registers of the current segment.
  always_ff @(posedge clk) begin
    addr     <= addr_nx;
    len      <= len_nx;
    nres     <= nres_nx;
    last_seg <= last_seg_nx;
    pend     <= pend_nx;
  end

  // A result is only pushed into a free output slot.
  a_push_free: assert property (@(posedge clk) disable iff (rst) push |-> free)
    else $error("result pushed into an occupied output register");

  // The result count of a segment never passes its limit.
  a_nres_max: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (nres <= RES_W'(MAX_RESULTS)))
    else $error("result count above limit");

  // The entry count never passes its limit.
  a_em_max: assert property (@(posedge clk) disable iff (rst)
    entries_made <= EM_W'(MAX_ENTRIES))
    else $error("entry count above limit");

  // Room in the current page never exceeds one page.
  a_page_left: assert property (@(posedge clk) disable iff (rst)
    page_left <= PL_W'(PAGE_BYTES))
    else $error("page room above page size");

  // An error result leaves the transfer marked as failed.
  a_fail_mark: assert property (@(posedge clk) disable iff (rst)
    (push && push_res.done_res && push_res.status != ST_OK) |-> (failed_code != ST_OK))
    else $error("error result without failure mark");

endmodule

`default_nettype wire
